/* src/sra_pkg.sv */
// shared widths, codes, state and status types for the shard resource allocator
`default_nettype none

package sra_pkg;

	// field and datapath widths
	localparam int CfgW     = 16;
	localparam int BacklogW = 16;
	localparam int LoadW    = 19;
	localparam int BaseW    = 17;
	localparam int ProdW    = 38;
	localparam int NumW     = 40;
	localparam int DenW     = 36;
	localparam int GrantW   = 31;
	localparam int TotalW   = 40;
	localparam int ThrW     = 18;
	localparam int SqW      = 34;
	localparam int RootW    = 17;
	localparam int HiW      = NumW - GrantW;
	localparam int DivCntW  = 5;
	localparam int CfgIdxW  = 2;

	localparam logic [GrantW-1:0] GRANT_MAX = '1;
	localparam logic [TotalW-1:0] TOTAL_MAX = '1;
	localparam logic [CfgW-1:0]   PENALTY_RST = CfgW'(1);

	// register indexes on the config port
	typedef enum logic [CfgIdxW-1:0] {
		CFG_PENALTY  = 2'd0,
		CFG_POWER_Q  = 2'd1,
		CFG_BW_Q     = 2'd2
	} sra_cfg_idx_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_L,
		ST_MUL_P,
		ST_MUL_B,
		ST_DIVP_GO,
		ST_DIVP_WAIT,
		ST_DIVB_GO,
		ST_DIVB_WAIT,
		ST_SQP_GO,
		ST_SQP_WAIT,
		ST_SQB_GO,
		ST_SQB_WAIT,
		ST_TOTAL
	} sra_state_t;

	// divider status back to the sequencer
	typedef struct packed {
		logic              done;
		logic              sat;
		logic [GrantW-1:0] quo;
	} sra_div_res_t;

	// square root status back to the sequencer
	typedef struct packed {
		logic             done;
		logic [RootW-1:0] root;
	} sra_sqrt_res_t;

endpackage

`default_nettype wire

/* src/sra_if.sv */
// valid/ready channel interfaces for shard items and allocation results
`default_nettype none

interface sra_shard_if import sra_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BacklogW-1:0] shard_backlog;
	logic                last_shard;

	modport source (output valid, output shard_backlog, output last_shard, input ready);
	modport sink (input valid, input shard_backlog, input last_shard, output ready);
endinterface

interface sra_result_if import sra_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [GrantW-1:0] power_grant;
	logic [GrantW-1:0] bandwidth_grant;
	logic [ThrW-1:0]   shard_throughput;
	logic [TotalW-1:0] power_total;
	logic [TotalW-1:0] bandwidth_total;
	logic              saturated;
	logic              batch_end;

	modport source (output valid, output power_grant, output bandwidth_grant,
		output shard_throughput, output power_total, output bandwidth_total,
		output saturated, output batch_end, input ready);
	modport sink (input valid, input power_grant, input bandwidth_grant,
		input shard_throughput, input power_total, input bandwidth_total,
		input saturated, input batch_end, output ready);
endinterface

`default_nettype wire

/* src/shard_resource_allocation.sv */
// drift-plus-penalty allocator top: config registers, sequencer, shared multiplier, totals
// items are taken one at a time, the next only once the sequencer is back in idle; the two 31-step divisions dominate
// one squaring multiplier, one divider and one square root unit are shared by both resources
// a finished result waits in an output register while the next item is taken
// arst_n clears the sequencer, output valid, batch totals and sets V to 1 and Z to 0
`default_nettype none

module shard_resource_allocation import sra_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	sra_shard_if.sink               shard,
	sra_result_if.source            result,
	input  wire logic               cfg_we,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0]    cfg_wdata
);

	sra_state_t state_q, state_n;

	logic [CfgW-1:0]   penalty_q;
	logic [CfgW-1:0]   zp_q;
	logic [CfgW-1:0]   zb_q;
	logic [TotalW-1:0] psum_q;
	logic [TotalW-1:0] bsum_q;

	logic [LoadW-1:0]  load_q;
	logic              last_q;
	logic [ProdW-1:0]  load_sq_q;
	logic [SqW-1:0]    bp_sq_q;
	logic [SqW-1:0]    bb_sq_q;
	logic [GrantW-1:0] gp_q;
	logic [GrantW-1:0] gb_q;
	logic [RootW-1:0]  rp_q;
	logic              sat_q;

	logic              out_valid_q;
	logic [GrantW-1:0] out_gp_q;
	logic [GrantW-1:0] out_gb_q;
	logic [ThrW-1:0]   out_thr_q;
	logic [TotalW-1:0] out_pt_q;
	logic [TotalW-1:0] out_bt_q;
	logic              out_sat_q;
	logic              out_end_q;

	logic              accept;
	logic              out_free;
	logic              out_load;
	logic [LoadW-1:0]  load_n;
	logic [BaseW-1:0]  base_p;
	logic [BaseW-1:0]  base_b;
	logic [LoadW-1:0]  mul_a;
	logic [ProdW-1:0]  mul_p;
	logic              div_start;
	logic [NumW-1:0]   div_num;
	logic [DenW-1:0]   div_den;
	sra_div_res_t      div_res;
	logic              sq_start;
	logic [SqW-1:0]    sq_v;
	sra_sqrt_res_t     sq_res;
	logic [TotalW:0]   psum_add;
	logic [TotalW:0]   bsum_add;
	logic [TotalW-1:0] pt_n;
	logic [TotalW-1:0] bt_n;
	logic              tot_sat;

	assign accept   = shard.valid && shard.ready;
	assign out_free = !out_valid_q || result.ready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			penalty_q <= PENALTY_RST;
			zp_q      <= '0;
			zb_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PENALTY: penalty_q <= cfg_wdata;
				CFG_POWER_Q: zp_q      <= cfg_wdata;
				CFG_BW_Q:    zb_q      <= cfg_wdata;
				default:     ;
			endcase
		end
	end

	// load Q + 5V and the two bases V + Z
	assign load_n = LoadW'(shard.shard_backlog) + LoadW'({penalty_q, 2'b00})
		+ LoadW'(penalty_q);
	assign base_p = BaseW'(penalty_q) + BaseW'(zp_q);
	assign base_b = BaseW'(penalty_q) + BaseW'(zb_q);

	// shared squaring multiplier
	always_comb begin
		case (state_q)
			ST_MUL_P: mul_a = LoadW'(base_p);
			ST_MUL_B: mul_a = LoadW'(base_b);
			default:  mul_a = load_q;
		endcase
	end
	assign mul_p = mul_a * mul_a;

	// divider operands: 5*load^2 or 4*load^2 over 4*base^2
	assign div_start = (state_q == ST_DIVP_GO) || (state_q == ST_DIVB_GO);
	always_comb begin
		if (state_q == ST_DIVP_GO) begin
			div_num = NumW'({load_sq_q, 2'b00}) + NumW'(load_sq_q);
			div_den = {bp_sq_q, 2'b00};
		end else begin
			div_num = NumW'({load_sq_q, 2'b00});
			div_den = {bb_sq_q, 2'b00};
		end
	end

	sra_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.res    (div_res)
	);

	// square root operands: 5*power grant or 4*bandwidth grant
	assign sq_start = (state_q == ST_SQP_GO) || (state_q == ST_SQB_GO);
	always_comb begin
		if (state_q == ST_SQP_GO) begin
			sq_v = SqW'({gp_q, 2'b00}) + SqW'(gp_q);
		end else begin
			sq_v = SqW'({gb_q, 2'b00});
		end
	end

	sra_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.v      (sq_v),
		.res    (sq_res)
	);

	// saturating batch totals
	assign psum_add = (TotalW+1)'(psum_q) + (TotalW+1)'(gp_q);
	assign bsum_add = (TotalW+1)'(bsum_q) + (TotalW+1)'(gb_q);
	assign pt_n     = psum_add[TotalW] ? TOTAL_MAX : psum_add[TotalW-1:0];
	assign bt_n     = bsum_add[TotalW] ? TOTAL_MAX : bsum_add[TotalW-1:0];
	assign tot_sat  = psum_add[TotalW] || bsum_add[TotalW];

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// next state and handshake
	always_comb begin
		state_n     = state_q;
		shard.ready = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				shard.ready = 1'b1;
				if (shard.valid) state_n = ST_MUL_L;
			end
			ST_MUL_L:     state_n = ST_MUL_P;
			ST_MUL_P:     state_n = ST_MUL_B;
			ST_MUL_B:     state_n = ST_DIVP_GO;
			ST_DIVP_GO:   state_n = ST_DIVP_WAIT;
			ST_DIVP_WAIT: if (div_res.done) state_n = ST_DIVB_GO;
			ST_DIVB_GO:   state_n = ST_DIVB_WAIT;
			ST_DIVB_WAIT: if (div_res.done) state_n = ST_SQP_GO;
			ST_SQP_GO:    state_n = ST_SQP_WAIT;
			ST_SQP_WAIT:  if (sq_res.done) state_n = ST_SQB_GO;
			ST_SQB_GO:    state_n = ST_SQB_WAIT;
			ST_SQB_WAIT:  if (sq_res.done) state_n = ST_TOTAL;
			ST_TOTAL: begin
				if (out_free) begin
					out_load = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default:      state_n = ST_IDLE;
		endcase
	end

	// working registers of one item
	always_ff @(posedge clk) begin
		if (accept) begin
			load_q <= load_n;
			last_q <= shard.last_shard;
			sat_q  <= 1'b0;
		end
		if (state_q == ST_MUL_L) load_sq_q <= mul_p;
		if (state_q == ST_MUL_P) bp_sq_q   <= mul_p[SqW-1:0];
		if (state_q == ST_MUL_B) bb_sq_q   <= mul_p[SqW-1:0];
		if ((state_q == ST_DIVP_WAIT) && div_res.done) begin
			gp_q  <= div_res.quo;
			sat_q <= sat_q || div_res.sat;
		end
		if ((state_q == ST_DIVB_WAIT) && div_res.done) begin
			gb_q  <= div_res.quo;
			sat_q <= sat_q || div_res.sat;
		end
		if ((state_q == ST_SQP_WAIT) && sq_res.done) rp_q <= sq_res.root;
	end

	// batch totals, cleared after the last shard
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum_q <= '0;
			bsum_q <= '0;
		end else if (out_load) begin
			psum_q <= last_q ? '0 : pt_n;
			bsum_q <= last_q ? '0 : bt_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_gp_q  <= gp_q;
			out_gb_q  <= gb_q;
			out_thr_q <= ThrW'(rp_q) + ThrW'(sq_res.root);
			out_pt_q  <= pt_n;
			out_bt_q  <= bt_n;
			out_sat_q <= sat_q || tot_sat;
			out_end_q <= last_q;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.power_grant      = out_gp_q;
	assign result.bandwidth_grant  = out_gb_q;
	assign result.shard_throughput = out_thr_q;
	assign result.power_total      = out_pt_q;
	assign result.bandwidth_total  = out_bt_q;
	assign result.saturated        = out_sat_q;
	assign result.batch_end        = out_end_q;

endmodule

`default_nettype wire

/* src/sra_div.sv */
// restoring divider, one quotient bit per cycle, with saturation check up front
`default_nettype none

module sra_div import sra_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [NumW-1:0] num,
	input  wire logic [DenW-1:0] den,
	output sra_div_res_t         res
);

	logic               busy_q;
	logic               done_q;
	logic               sat_q;
	logic [DivCntW-1:0] cnt_q;
	logic [DenW-1:0]    rem_q;
	logic [DenW-1:0]    den_q;
	logic [GrantW-1:0]  low_q;
	logic [GrantW-1:0]  quo_q;
	logic               ovf;
	logic [DenW:0]      trial;
	logic [DenW:0]      diff;
	logic               ge;

	// quotient needs more than GrantW bits, or divisor is zero
	assign ovf = (den[DenW-1:HiW] == '0) && (num[NumW-1:GrantW] >= den[HiW-1:0]);

	// one trial subtraction per cycle
	assign trial = {rem_q, low_q[GrantW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (ovf) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= DivCntW'(GrantW);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - DivCntW'(1);
				if (cnt_q == DivCntW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			sat_q <= ovf;
			quo_q <= GRANT_MAX;
			rem_q <= DenW'(num[NumW-1:GrantW]);
			low_q <= num[GrantW-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DenW-1:0] : trial[DenW-1:0];
			low_q <= {low_q[GrantW-2:0], 1'b0};
			quo_q <= {quo_q[GrantW-2:0], ge};
		end
	end

	assign res.done = done_q;
	assign res.sat  = sat_q;
	assign res.quo  = quo_q;

endmodule

`default_nettype wire

/* src/sra_isqrt.sv */
// integer square root, one result bit per cycle
`default_nettype none

module sra_isqrt import sra_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [SqW-1:0] v,
	output sra_sqrt_res_t       res
);

	logic           busy_q;
	logic           done_q;
	logic [SqW-1:0] val_q;
	logic [SqW:0]   root_q;
	logic [SqW:0]   bit_q;
	logic [SqW:0]   trial;
	logic           ge;

	assign trial = root_q + bit_q;
	assign ge    = {1'b0, val_q} >= trial;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// digit step
	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= v;
			root_q <= '0;
			bit_q  <= (SqW+1)'(1) << (SqW - 2);
		end else if (busy_q) begin
			if (ge) begin
				val_q  <= val_q - trial[SqW-1:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign res.done = done_q;
	assign res.root = root_q[RootW-1:0];

endmodule

`default_nettype wire

/* src/sra_checker.sv */
// port-level checks for the shard resource allocator, bound to the top level
`default_nettype none

module sra_checker import sra_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              shard_valid,
	input wire logic              shard_ready,
	input wire logic              result_valid,
	input wire logic              result_ready,
	input wire logic [GrantW-1:0] power_grant,
	input wire logic [GrantW-1:0] bandwidth_grant,
	input wire logic [TotalW-1:0] power_total,
	input wire logic [TotalW-1:0] bandwidth_total,
	input wire logic              saturated
);

	// a waiting result holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(power_grant)
			&& $stable(power_total))
		else $error("result dropped or changed while stalled");

	// no second item is taken while one is in work
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		shard_valid && shard_ready |=> !shard_ready)
		else $error("item accepted while busy");

	// an unclipped total includes this shard's grant
	a_total_covers_grant: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !saturated |-> (power_total >= TotalW'(power_grant))
			&& (bandwidth_total >= TotalW'(bandwidth_grant)))
		else $error("total below grant without saturation");

endmodule

bind shard_resource_allocation sra_checker u_sra_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.shard_valid     (shard.valid),
	.shard_ready     (shard.ready),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.power_grant     (result.power_grant),
	.bandwidth_grant (result.bandwidth_grant),
	.power_total     (result.power_total),
	.bandwidth_total (result.bandwidth_total),
	.saturated       (result.saturated)
);

`default_nettype wire

/* test/shard_resource_allocation_tb.sv */
// self-checking testbench for the shard resource allocator: directed corners, random batches
`default_nettype none

module shard_resource_allocation_tb;
	import sra_pkg::*;

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int ITEM_TARGET = 1400;
	localparam int DRAIN_CYCLES = 120;
	localparam int TOTALS_FILL = 520;
	localparam logic [63:0] POWER_WEIGHT = 64'd5;
	localparam logic [63:0] BW_WEIGHT = 64'd4;
	localparam logic [63:0] LOAD_PER_V = 64'd5;
	localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

	// one shard waiting to be sent
	typedef struct packed {
		logic [BacklogW-1:0] backlog;
		logic                last;
	} shard_t;

	// one predicted allocation
	typedef struct packed {
		logic [GrantW-1:0] power_grant;
		logic [GrantW-1:0] bandwidth_grant;
		logic [ThrW-1:0]   shard_throughput;
		logic [TotalW-1:0] power_total;
		logic [TotalW-1:0] bandwidth_total;
		logic              saturated;
		logic              batch_end;
	} allocation_t;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_FREE,
		RX_CHOPPY,
		RX_LONG_STALL
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic send_valid = 1'b0;
	logic [BacklogW-1:0] send_backlog = '0;
	logic send_last = 1'b0;
	logic take_ready = 1'b0;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgW-1:0] cfg_wdata = '0;

	// mirror of the block's registers and batch sums
	logic [CfgW-1:0] penalty_v = PENALTY_RST;
	logic [CfgW-1:0] power_z = '0;
	logic [CfgW-1:0] bandwidth_z = '0;
	logic [TotalW-1:0] power_sum = '0;
	logic [TotalW-1:0] bandwidth_sum = '0;

	shard_t shards_to_send[$];
	allocation_t pending_allocations[$];
	int items_queued = 0;
	int results_seen = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int burst_left = 1;
	int gap_left = 0;
	int stall_left = 0;
	int mode_left = 0;
	rx_mode_t rx_mode = RX_FREE;

	sra_shard_if shard_ch();
	sra_result_if result_ch();

	assign shard_ch.valid = send_valid;
	assign shard_ch.shard_backlog = send_backlog;
	assign shard_ch.last_shard = send_last;
	assign result_ch.ready = take_ready;

	shard_resource_allocation i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.shard     (shard_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// unsaturated quotient; a zero divisor gives a value that always clips
	function automatic logic [63:0] raw_grant(logic [63:0] weight, logic [63:0] load,
			logic [CfgW-1:0] z);
		logic [63:0] base;
		base = 64'(penalty_v) + 64'(z);
		if (base == 64'd0) begin
			return '1;
		end
		return (weight * load * load) / (64'd4 * base * base);
	endfunction

	// floor square root, one result bit at a time from the top
	function automatic logic [RootW-1:0] isqrt(logic [63:0] v);
		logic [RootW-1:0] root;
		logic [RootW-1:0] trial;
		root = '0;
		for (int b = RootW - 1; b >= 0; b--) begin
			trial = root | (RootW'(1) << b);
			if (64'(trial) * 64'(trial) <= v) begin
				root = trial;
			end
		end
		return root;
	endfunction

	// grants, throughput and batch totals for one shard; advances the sums
	function automatic allocation_t allocate_shard(logic [BacklogW-1:0] backlog, logic last);
		allocation_t a;
		logic [63:0] load;
		logic [63:0] pg;
		logic [63:0] bg;
		logic [63:0] ps;
		logic [63:0] bs;
		logic sat;
		sat = 1'b0;
		load = 64'(backlog) + LOAD_PER_V * 64'(penalty_v);
		pg = raw_grant(POWER_WEIGHT, load, power_z);
		bg = raw_grant(BW_WEIGHT, load, bandwidth_z);
		if (pg > 64'(GRANT_MAX)) begin
			sat = 1'b1;
			pg = 64'(GRANT_MAX);
		end
		if (bg > 64'(GRANT_MAX)) begin
			sat = 1'b1;
			bg = 64'(GRANT_MAX);
		end
		ps = 64'(power_sum) + pg;
		bs = 64'(bandwidth_sum) + bg;
		if (ps > 64'(TOTAL_MAX)) begin
			sat = 1'b1;
			ps = 64'(TOTAL_MAX);
		end
		if (bs > 64'(TOTAL_MAX)) begin
			sat = 1'b1;
			bs = 64'(TOTAL_MAX);
		end
		a.power_grant = pg[GrantW-1:0];
		a.bandwidth_grant = bg[GrantW-1:0];
		a.shard_throughput = ThrW'(isqrt(POWER_WEIGHT * pg)) + ThrW'(isqrt(BW_WEIGHT * bg));
		a.power_total = ps[TotalW-1:0];
		a.bandwidth_total = bs[TotalW-1:0];
		a.saturated = sat;
		a.batch_end = last;
		if (last) begin
			power_sum = '0;
			bandwidth_sum = '0;
		end else begin
			power_sum = ps[TotalW-1:0];
			bandwidth_sum = bs[TotalW-1:0];
		end
		return a;
	endfunction

	task automatic check_field(string field, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatch_count++;
		end
	endtask

	// sender: bursts of items from the queue with random gaps
	always @(posedge clk or negedge arst_n) begin
		shard_t nxt;
		if (!arst_n) begin
			send_valid <= 1'b0;
		end else begin
			if (send_valid && shard_ch.ready) begin
				pending_allocations.push_back(allocate_shard(send_backlog, send_last));
			end
			if (!send_valid || shard_ch.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					send_valid <= 1'b0;
				end else if (shards_to_send.size() != 0) begin
					nxt = shards_to_send.pop_front();
					send_backlog <= nxt.backlog;
					send_last <= nxt.last;
					send_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else if ($urandom_range(0, 3) == 0) begin
						burst_left = $urandom_range(40, 200);
						gap_left = 0;
					end else begin
						burst_left = $urandom_range(1, 8);
						gap_left = $urandom_range(0, 1) ? $urandom_range(0, 8)
							: $urandom_range(0, 140);
					end
				end else begin
					send_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each result against the oldest prediction, stall by pattern
	always @(posedge clk or negedge arst_n) begin
		allocation_t want;
		if (!arst_n) begin
			take_ready <= 1'b0;
		end else begin
			if (result_ch.valid && take_ready) begin
				if (pending_allocations.size() == 0) begin
					$error("allocation result with no shard outstanding");
					mismatch_count++;
				end else begin
					want = pending_allocations.pop_front();
					results_seen++;
					check_field("power_grant", 64'(want.power_grant),
						64'(result_ch.power_grant));
					check_field("bandwidth_grant", 64'(want.bandwidth_grant),
						64'(result_ch.bandwidth_grant));
					check_field("shard_throughput", 64'(want.shard_throughput),
						64'(result_ch.shard_throughput));
					check_field("power_total", 64'(want.power_total),
						64'(result_ch.power_total));
					check_field("bandwidth_total", 64'(want.bandwidth_total),
						64'(result_ch.bandwidth_total));
					check_field("saturated", 64'(want.saturated), 64'(result_ch.saturated));
					check_field("batch_end", 64'(want.batch_end), 64'(result_ch.batch_end));
				end
			end
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(200, 3000);
			end else begin
				mode_left--;
			end
			if (stall_left > 0) begin
				stall_left--;
				take_ready <= 1'b0;
			end else begin
				take_ready <= 1'b1;
				case (rx_mode)
					RX_CHOPPY: begin
						if ($urandom_range(0, 1) == 1) begin
							stall_left = $urandom_range(1, 4);
						end
					end
					RX_LONG_STALL: begin
						if ($urandom_range(0, 15) == 0) begin
							stall_left = $urandom_range(10, 150);
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("shard_resource_allocation_tb failed");
			$finish;
		end
	end

	// register write, mirrored once the block has taken it
	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_PENALTY: penalty_v = value;
			CFG_POWER_Q: power_z = value;
			CFG_BW_Q:    bandwidth_z = value;
			default: begin
			end
		endcase
	endtask

	task automatic send_shard(logic [BacklogW-1:0] backlog, logic last);
		shards_to_send.push_back('{backlog: backlog, last: last});
		items_queued++;
	endtask

	// wait until every queued shard has come back, then let the block settle
	task automatic wait_idle();
		while (results_seen != items_queued) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	// values biased toward the ends and toward small magnitudes
	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'hFFFF;
			2, 3: return 16'($urandom_range(0, 65535) >> $urandom_range(1, 15));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	initial begin
		int odds;
		int phase_len;
		logic fill_done;
		fill_done = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: smallest and largest backlog, grant overflow at full backlog
		send_shard(16'd0, 1'b0);
		send_shard(16'hFFFF, 1'b0);
		send_shard(16'd1, 1'b0);
		send_shard(16'h8000, 1'b1);
		wait_idle();

		// zero divisor on both resources, also with zero load
		write_reg(CFG_PENALTY, 16'd0);
		write_reg(CFG_POWER_Q, 16'd0);
		write_reg(CFG_BW_Q, 16'd0);
		send_shard(16'd0, 1'b0);
		send_shard(16'hFFFF, 1'b0);
		send_shard(16'd12345, 1'b1);
		wait_idle();

		// zero divisor on power only, zero load on bandwidth
		write_reg(CFG_BW_Q, 16'd3);
		send_shard(16'd0, 1'b0);
		send_shard(16'hFFFF, 1'b1);
		wait_idle();

		// all registers at their maximum
		write_reg(CFG_PENALTY, 16'hFFFF);
		write_reg(CFG_POWER_Q, 16'hFFFF);
		write_reg(CFG_BW_Q, 16'hFFFF);
		send_shard(16'd0, 1'b0);
		send_shard(16'hFFFF, 1'b1);
		send_shard(16'h5555, 1'b0);
		send_shard(16'hAAAA, 1'b1);
		wait_idle();

		// write to the unused index must change nothing
		write_reg(CFG_SPARE, 16'h0001);
		send_shard(16'd1000, 1'b1);
		wait_idle();

		// mixed: small V, power queue empty, bandwidth queue full
		write_reg(CFG_PENALTY, 16'd7);
		write_reg(CFG_POWER_Q, 16'd0);
		send_shard(16'd0, 1'b0);
		send_shard(16'hFFFF, 1'b0);
		send_shard(16'd300, 1'b1);
		wait_idle();

		// random phases with fresh settings, one long batch that overflows the totals
		while (items_queued < ITEM_TARGET) begin
			if (!fill_done && items_queued > 400) begin
				fill_done = 1'b1;
				write_reg(CFG_PENALTY, 16'd0);
				write_reg(CFG_POWER_Q, 16'd0);
				write_reg(CFG_BW_Q, 16'd0);
				for (int i = 0; i < TOTALS_FILL; i++) begin
					send_shard(pick_value(), 1'b0);
				end
				send_shard(pick_value(), 1'b1);
				send_shard(pick_value(), 1'b1);
				wait_idle();
			end
			if ($urandom_range(0, 1) == 1) begin
				write_reg(CFG_PENALTY, pick_value());
			end
			if ($urandom_range(0, 1) == 1) begin
				write_reg(CFG_POWER_Q, pick_value());
			end
			if ($urandom_range(0, 1) == 1) begin
				write_reg(CFG_BW_Q, pick_value());
			end
			if ($urandom_range(0, 9) == 0) begin
				write_reg(CFG_SPARE, pick_value());
			end
			case ($urandom_range(0, 2))
				0: odds = 2;
				1: odds = 6;
				default: odds = 25;
			endcase
			phase_len = $urandom_range(10, 60);
			for (int i = 0; i < phase_len; i++) begin
				send_shard(pick_value(), $urandom_range(1, odds) == 1);
			end
			wait_idle();
		end

		// drain and report
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_allocations.size() != 0) begin
			$error("%0d predicted allocations never came out", pending_allocations.size());
		end
		if (mismatch_count == 0 && pending_allocations.size() == 0) begin
			$display("shard_resource_allocation_tb passed");
		end else begin
			$display("shard_resource_allocation_tb failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* filelist.f */
src/sra_pkg.sv
src/sra_if.sv
src/sra_div.sv
src/sra_isqrt.sv
src/shard_resource_allocation.sv
src/sra_checker.sv
test/shard_resource_allocation_tb.sv
